### rtl/qitm_pkg.sv
// Shared types and constants for the quaternion integrator core.
// Used by qitm_mul, qitm_div and quaternion_integrate_to_matrix_core.
`default_nettype none

package qitm_pkg;

  // Default number of fraction bits of the quaternion state
  localparam int QUAT_FRAC_BITS_DEF = 30;

  // Fixed fraction bits of the rate input and the time step
  localparam int RATE_FRAC = 20;
  localparam int STEP_FRAC = 24;

  // Shared multiplier: 64x64 signed, built from 33x33 partial products
  localparam int MUL_W     = 64;
  localparam int MUL_CHUNK = 31;
  localparam int MUL_PW    = 2 * (MUL_W - MUL_CHUNK);
  localparam int ACC_W     = 100;

  // Shared divider: unsigned, one quotient bit per cycle
  localparam int DIV_W = 64;

  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic              renormalized;
  } out_t;

  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/quaternion_integrate_to_matrix_core.sv
// Quaternion attitude integrator with rotation matrix output: sequencer top.
// Depends on qitm_pkg, qitm_mul (shared multiplier) and qitm_div (divider).
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 24-bit time step;
//   cfg_ready is always high. Write it only while the core is idle.
//   in channel carries one rate vector per transaction; in_ready is high only
//   while the sequencer is idle, one item is in work at a time.
//   out channel returns one matrix and the renormalized flag per input.
// Sequencing: the sequencer runs 35 multiplies on the shared multiplier and
//   one division from the input transaction to out_valid. A renormalizing
//   item adds 8 multiplies and a second division. The next input can be
//   accepted in the cycle after the result is handed off; the shared
//   multiplier and divider set the rate.
// The result sits in an output register, so a stalled receiver does not stop
//   the next item; only the handoff of the following result waits for it.
// Reset (rst, synchronous) sets the quaternion to identity, the time step to
//   zero and drops any item in work.
`default_nettype none

module quaternion_integrate_to_matrix_core #(
  parameter int QUAT_FRAC_BITS = qitm_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [23:0]    cfg_data,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire qitm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output qitm_pkg::out_t      out_data
);

  localparam int F  = QUAT_FRAC_BITS;
  localparam int AW = qitm_pkg::ACC_W;

  localparam logic [63:0] ONE64 = 64'd1 << F;
  localparam logic [63:0] TOL_LO = (ONE64 * 64'd9999 + 64'd5000) / 64'd10000;
  localparam logic [63:0] TOL_HI = (ONE64 * 64'd10001 + 64'd5000) / 64'd10000;
  localparam logic [63:0] VNUM  = 64'd1 << (2 * F + 1);

  localparam logic signed [AW-1:0] S32_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AW-1:0] S32_MIN = {{(AW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [AW-1:0] ONE_A   = {{(AW-1){1'b0}}, 1'b1} << F;
  localparam logic signed [AW-1:0] TWO_A   = ONE_A <<< 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RATE, S_SQ, S_NDIV, S_RESC, S_VDIV, S_PAIR, S_MAT, S_DONE
  } state_t;

  state_t             state;
  logic [3:0]         idx;
  logic               pend;
  logic               rescaled;
  logic               ren;
  logic [23:0]        tstep;
  logic signed [31:0] rx, ry, rz;
  logic signed [31:0] qw, qx, qy, qz;
  logic signed [31:0] nq [4];
  logic signed [47:0] ssum;
  logic [63:0]        l2;
  logic [63:0]        nfac;
  logic [63:0]        vel;
  logic signed [63:0] sq [4];
  logic signed [63:0] pr [6];
  logic signed [31:0] mm [9];

  qitm_pkg::mul_req_t mreq;
  qitm_pkg::mul_rsp_t mrsp;
  qitm_pkg::div_req_t dreq;
  qitm_pkg::div_rsp_t drsp;

  // Combinational operand selection and post-processing
  logic [1:0]         src;
  logic               neg;
  logic signed [31:0] qa;
  logic signed [31:0] qb;
  logic signed [31:0] rsel;
  logic signed [AW-1:0] ps_r, ps_s, ps_f;
  logic signed [47:0] term;
  logic signed [47:0] ssum_next;
  logic signed [47:0] qold;
  logic signed [47:0] nq_wide;
  logic signed [31:0] nq_val;
  logic signed [63:0] sq_val;
  logic [63:0]        l2_sum;
  logic               ren_now;
  logic signed [31:0] resc_val;
  logic signed [63:0] msum;
  logic               mdiag;
  logic signed [AW-1:0] rc;
  logic signed [AW-1:0] dv;
  logic signed [31:0] mat_val;
  logic [63:0]        l2_den;

  function automatic logic signed [31:0] qsel(input logic [1:0] s,
                                             input logic signed [31:0] w,
                                             input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z);
    logic signed [31:0] r;
    unique case (s)
      2'd0:    r = w;
      2'd1:    r = x;
      2'd2:    r = y;
      default: r = z;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fff_ffff;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Source component and sign of each rate term
  always_comb begin
    src = 2'd0;
    neg = 1'b0;
    unique case (idx)
      4'd0:  src = 2'd1;
      4'd1:  src = 2'd2;
      4'd2:  src = 2'd3;
      4'd4:  src = 2'd0;
      4'd5:  begin src = 2'd3; neg = 1'b1; end
      4'd6:  src = 2'd2;
      4'd8:  src = 2'd3;
      4'd9:  src = 2'd0;
      4'd10: begin src = 2'd1; neg = 1'b1; end
      4'd12: begin src = 2'd2; neg = 1'b1; end
      4'd13: src = 2'd1;
      4'd14: src = 2'd0;
      default: begin src = 2'd0; neg = 1'b0; end
    endcase
  end

  // Multiplier operands per sequencer step
  always_comb begin
    qa = qsel(src, qw, qx, qy, qz);
    qb = qa;
    unique case (idx[1:0])
      2'd0:    rsel = rx;
      2'd1:    rsel = ry;
      default: rsel = rz;
    endcase
    msum  = '0;
    mdiag = 1'b0;
    unique case (idx)
      4'd0:    begin msum = sq[2] + sq[3]; mdiag = 1'b1; end
      4'd1:    msum = pr[0] + pr[1];
      4'd2:    msum = pr[2] - pr[3];
      4'd3:    msum = pr[0] - pr[1];
      4'd4:    begin msum = sq[3] + sq[1]; mdiag = 1'b1; end
      4'd5:    msum = pr[4] + pr[5];
      4'd6:    msum = pr[2] + pr[3];
      4'd7:    msum = pr[4] - pr[5];
      4'd8:    begin msum = sq[1] + sq[2]; mdiag = 1'b1; end
      default: msum = '0;
    endcase
    mreq.a = '0;
    mreq.b = '0;
    unique case (state)
      S_RATE: begin
        if (idx[1:0] == 2'd3) begin
          mreq.a = 64'(ssum);
          mreq.b = {40'd0, tstep};
        end else begin
          mreq.a = 64'(qa);
          mreq.b = 64'(rsel);
        end
      end
      S_SQ: begin
        mreq.a = 64'(qsel(idx[1:0], qw, qx, qy, qz));
        mreq.b = 64'(qsel(idx[1:0], qw, qx, qy, qz));
      end
      S_RESC: begin
        mreq.a = 64'(qsel(idx[1:0], qw, qx, qy, qz));
        mreq.b = $signed(nfac);
      end
      S_PAIR: begin
        unique case (idx)
          4'd0:    begin qa = qx; qb = qy; end
          4'd1:    begin qa = qw; qb = qz; end
          4'd2:    begin qa = qx; qb = qz; end
          4'd3:    begin qa = qw; qb = qy; end
          4'd4:    begin qa = qy; qb = qz; end
          default: begin qa = qw; qb = qx; end
        endcase
        mreq.a = 64'(qa);
        mreq.b = 64'(qb);
      end
      S_MAT: begin
        mreq.a = $signed(vel);
        mreq.b = msum;
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
    mreq.start = !pend && (state == S_RATE || state == S_SQ || state == S_RESC ||
                           state == S_PAIR || state == S_MAT);
  end

  // Divider operands: rescale factor, then the matrix scale
  always_comb begin
    l2_den     = (l2 == 64'd0) ? 64'd1 : l2;
    dreq.start = !pend && (state == S_NDIV || state == S_VDIV);
    dreq.den   = l2_den;
    dreq.num   = (state == S_NDIV) ? ((l2 + ONE64) << (F - 1)) : VNUM;
  end

  // Post-process the finished product
  always_comb begin
    ps_r      = mrsp.prod >>> qitm_pkg::RATE_FRAC;
    ps_s      = mrsp.prod >>> qitm_pkg::STEP_FRAC;
    ps_f      = mrsp.prod >>> F;
    term      = ps_r[47:0];
    ssum_next = ((idx[1:0] == 2'd0) ? 48'sd0 : ssum) + (neg ? -term : term);
    qold      = 48'(qsel(idx[3:2], qw, qx, qy, qz));
    nq_wide   = (idx[3:2] == 2'd0) ? (qold - ps_s[47:0]) : (qold + ps_s[47:0]);
    nq_val    = sat32(AW'(nq_wide));
    sq_val    = ps_f[63:0];
    l2_sum    = l2 + sq_val;
    ren_now   = (l2_sum < TOL_LO) || (l2_sum > TOL_HI);
    resc_val  = sat32(ps_f);
    if (mdiag) begin
      if (ps_f > TWO_A) rc = TWO_A;
      else if (ps_f < -TWO_A) rc = -TWO_A;
      else rc = ps_f;
      dv = ONE_A - rc;
    end else begin
      rc = '0;
      dv = ps_f;
    end
    if (dv > ONE_A) mat_val = ONE_A[31:0];
    else if (dv < -ONE_A) mat_val = -ONE_A[31:0];
    else mat_val = dv[31:0];
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Sequencer: state, quaternion state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= 4'd0;
      pend      <= 1'b0;
      rescaled  <= 1'b0;
      ren       <= 1'b0;
      out_valid <= 1'b0;
      tstep     <= 24'd0;
      qw        <= 32'(ONE64);
      qx        <= 32'sd0;
      qy        <= 32'sd0;
      qz        <= 32'sd0;
    end else begin
      if (cfg_valid) begin
        tstep <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rx       <= in_data.rate_x;
            ry       <= in_data.rate_y;
            rz       <= in_data.rate_z;
            idx      <= 4'd0;
            pend     <= 1'b0;
            rescaled <= 1'b0;
            state    <= S_RATE;
          end
        end
        S_RATE: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (mrsp.done) begin
            pend <= 1'b0;
            idx  <= idx + 4'd1;
            if (idx[1:0] == 2'd3) begin
              nq[idx[3:2]] <= nq_val;
            end else begin
              ssum <= ssum_next;
            end
            if (idx == 4'd15) begin
              qw    <= nq[0];
              qx    <= nq[1];
              qy    <= nq[2];
              qz    <= nq_val;
              l2    <= 64'd0;
              idx   <= 4'd0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (mrsp.done) begin
            pend         <= 1'b0;
            sq[idx[1:0]] <= sq_val;
            l2           <= l2_sum;
            idx          <= idx + 4'd1;
            if (idx == 4'd3) begin
              idx <= 4'd0;
              if (!rescaled) begin
                ren <= ren_now;
              end
              if (!rescaled && ren_now) begin
                state <= S_NDIV;
              end else begin
                state <= S_VDIV;
              end
            end
          end
        end
        S_NDIV: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (drsp.done) begin
            pend  <= 1'b0;
            nfac  <= drsp.quot;
            idx   <= 4'd0;
            state <= S_RESC;
          end
        end
        S_RESC: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (mrsp.done) begin
            pend <= 1'b0;
            idx  <= idx + 4'd1;
            unique case (idx[1:0])
              2'd0:    qw <= resc_val;
              2'd1:    qx <= resc_val;
              2'd2:    qy <= resc_val;
              default: qz <= resc_val;
            endcase
            if (idx == 4'd3) begin
              rescaled <= 1'b1;
              l2       <= 64'd0;
              idx      <= 4'd0;
              state    <= S_SQ;
            end
          end
        end
        S_VDIV: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (drsp.done) begin
            pend  <= 1'b0;
            vel   <= drsp.quot;
            idx   <= 4'd0;
            state <= S_PAIR;
          end
        end
        S_PAIR: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (mrsp.done) begin
            pend <= 1'b0;
            idx  <= idx + 4'd1;
            unique case (idx)
              4'd0:    pr[0] <= sq_val;
              4'd1:    pr[1] <= sq_val;
              4'd2:    pr[2] <= sq_val;
              4'd3:    pr[3] <= sq_val;
              4'd4:    pr[4] <= sq_val;
              default: pr[5] <= sq_val;
            endcase
            if (idx == 4'd5) begin
              idx   <= 4'd0;
              state <= S_MAT;
            end
          end
        end
        S_MAT: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (mrsp.done) begin
            pend <= 1'b0;
            idx  <= idx + 4'd1;
            unique case (idx)
              4'd0:    mm[0] <= mat_val;
              4'd1:    mm[1] <= mat_val;
              4'd2:    mm[2] <= mat_val;
              4'd3:    mm[3] <= mat_val;
              4'd4:    mm[4] <= mat_val;
              4'd5:    mm[5] <= mat_val;
              4'd6:    mm[6] <= mat_val;
              4'd7:    mm[7] <= mat_val;
              default: mm[8] <= mat_val;
            endcase
            if (idx == 4'd8) begin
              idx   <= 4'd0;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // Hand off once the output register is free
          if (!out_valid || out_ready) begin
            out_data.m00          <= mm[0];
            out_data.m01          <= mm[1];
            out_data.m02          <= mm[2];
            out_data.m10          <= mm[3];
            out_data.m11          <= mm[4];
            out_data.m12          <= mm[5];
            out_data.m20          <= mm[6];
            out_data.m21          <= mm[7];
            out_data.m22          <= mm[8];
            out_data.renormalized <= ren;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  qitm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  qitm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

endmodule

`default_nettype wire

### rtl/qitm_mul.sv
// Shared multi-cycle 64x64 signed multiplier for the quaternion core.
// Depends on qitm_pkg; one 33x33 partial product per cycle, accumulated.
`default_nettype none

module qitm_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire qitm_pkg::mul_req_t req,
  output qitm_pkg::mul_rsp_t     rsp
);

  localparam int HW = qitm_pkg::MUL_W - qitm_pkg::MUL_CHUNK;

  logic signed [qitm_pkg::MUL_W-1:0]  a_r;
  logic signed [qitm_pkg::MUL_W-1:0]  b_r;
  logic signed [qitm_pkg::MUL_PW-1:0] preg;
  logic [6:0]                         psh;
  logic signed [qitm_pkg::ACC_W-1:0]  acc;
  logic [2:0]                         cnt;
  logic                               busy;
  logic                               done;
  logic signed [HW-1:0]               a_ch;
  logic signed [HW-1:0]               b_ch;

  // Pick the low (unsigned) or high (signed) chunk of each operand
  always_comb begin
    a_ch = cnt[0] ? a_r[qitm_pkg::MUL_W-1:qitm_pkg::MUL_CHUNK]
                  : {2'b00, a_r[qitm_pkg::MUL_CHUNK-1:0]};
    b_ch = cnt[1] ? b_r[qitm_pkg::MUL_W-1:qitm_pkg::MUL_CHUNK]
                  : {2'b00, b_r[qitm_pkg::MUL_CHUNK-1:0]};
  end

  // Multiply one chunk pair into preg, then accumulate it in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        acc  <= '0;
        a_r  <= req.a;
        b_r  <= req.b;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          preg <= a_ch * b_ch;
          psh  <= (cnt[0] ? 7'(qitm_pkg::MUL_CHUNK) : 7'd0)
                + (cnt[1] ? 7'(qitm_pkg::MUL_CHUNK) : 7'd0);
        end
        if (cnt != 3'd0) begin
          acc <= acc + (qitm_pkg::ACC_W'(preg) <<< psh);
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

`default_nettype wire

### rtl/qitm_div.sv
// Shared restoring divider for the quaternion core, one quotient bit a cycle.
// Depends on qitm_pkg for the operand width and request/response types.
`default_nettype none

module qitm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire qitm_pkg::div_req_t req,
  output qitm_pkg::div_rsp_t     rsp
);

  localparam int CW = $clog2(qitm_pkg::DIV_W);

  logic [qitm_pkg::DIV_W-1:0] rem;
  logic [qitm_pkg::DIV_W-1:0] qr;
  logic [qitm_pkg::DIV_W-1:0] den_r;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic                       done;
  logic [qitm_pkg::DIV_W:0]   r_sh;
  logic [qitm_pkg::DIV_W:0]   r_sub;
  logic                       fits;

  // Shift in the next numerator bit and trial-subtract the divisor
  always_comb begin
    r_sh  = {rem, qr[qitm_pkg::DIV_W-1]};
    r_sub = r_sh - {1'b0, den_r};
    fits  = r_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        qr    <= req.num;
        den_r <= req.den;
      end else if (busy) begin
        rem <= fits ? r_sub[qitm_pkg::DIV_W-1:0] : r_sh[qitm_pkg::DIV_W-1:0];
        qr  <= {qr[qitm_pkg::DIV_W-2:0], fits};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(qitm_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = qr;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for quaternion_integrate_to_matrix_core.
// Depends on qitm_pkg and the core RTL: a bit-exact predictor of the attitude
// update, renormalization and matrix output (or a typed expectation for known directed rows) checks every result.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F = qitm_pkg::QUAT_FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << F;
  localparam logic [23:0] STEP_MAX = 24'hFFFFFF;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [23:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  qitm_pkg::in_t in_data;
  qitm_pkg::out_t out_data;

  quaternion_integrate_to_matrix_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Attitude state and time step as the core should hold them
  logic signed [31:0] att_w, att_x, att_y, att_z;
  logic [23:0] step_reg;
  qitm_pkg::out_t matrix_q[$];
  int err_count = 0;

  function automatic longint mul_floor(longint a, longint b, int sh, longint lim);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> sh;
    if (p > lim) return lim;
    if (p < -lim) return -lim;
    return p[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (v < -longint'(32'sh80000000) * 0 - 64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint rate_term(logic signed [31:0] q, logic signed [31:0] r);
    return (longint'(q) * longint'(r)) >>> 20;
  endfunction

  function automatic longint fprod(logic signed [31:0] a, logic signed [31:0] b);
    return (longint'(a) * longint'(b)) >>> F;
  endfunction

  function automatic logic [63:0] norm_sq();
    return fprod(att_w, att_w) + fprod(att_x, att_x) + fprod(att_y, att_y)
         + fprod(att_z, att_z);
  endfunction

  function automatic logic [31:0] diag_entry(longint v, longint s);
    longint r;
    r = ONE - mul_floor(v, s, F, 2 * ONE);
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r[31:0];
  endfunction

  function automatic logic [31:0] off_entry(longint v, longint s);
    longint r;
    r = mul_floor(v, s, F, ONE);
    return r[31:0];
  endfunction

  // Advance the attitude by one rate sample and build the expected matrix
  function automatic qitm_pkg::out_t integrate_attitude(qitm_pkg::in_t r);
    qitm_pkg::out_t o;
    logic signed [31:0] w, x, y, z;
    longint sw, sx, sy, sz, st, n, v;
    longint x2, y2, z2, xy, wz, xz, wy, yz, wx;
    logic [63:0] l2, d, lo_b, hi_b;
    logic ren;
    w = att_w; x = att_x; y = att_y; z = att_z;
    st = longint'(step_reg);
    sw = rate_term(x, r.rate_x) + rate_term(y, r.rate_y) + rate_term(z, r.rate_z);
    sx = rate_term(w, r.rate_x) - rate_term(z, r.rate_y) + rate_term(y, r.rate_z);
    sy = rate_term(z, r.rate_x) + rate_term(w, r.rate_y) - rate_term(x, r.rate_z);
    sz = rate_term(x, r.rate_y) - rate_term(y, r.rate_x) + rate_term(w, r.rate_z);
    att_w = sat32(longint'(w) - mul_floor(sw, st, 24, longint'(1) << 62));
    att_x = sat32(longint'(x) + mul_floor(sx, st, 24, longint'(1) << 62));
    att_y = sat32(longint'(y) + mul_floor(sy, st, 24, longint'(1) << 62));
    att_z = sat32(longint'(z) + mul_floor(sz, st, 24, longint'(1) << 62));
    l2 = norm_sq();
    lo_b = (64'(ONE) * 9999 + 5000) / 10000;
    hi_b = (64'(ONE) * 10001 + 5000) / 10000;
    ren = (l2 < lo_b) || (l2 > hi_b);
    if (ren) begin
      d = (l2 != 0) ? l2 : 64'd1;
      n = ((l2 + 64'(ONE)) << (F - 1)) / d;
      att_w = sat32(mul_floor(att_w, n, F, 64'sh7FFFFFFFFFFFFFFF));
      att_x = sat32(mul_floor(att_x, n, F, 64'sh7FFFFFFFFFFFFFFF));
      att_y = sat32(mul_floor(att_y, n, F, 64'sh7FFFFFFFFFFFFFFF));
      att_z = sat32(mul_floor(att_z, n, F, 64'sh7FFFFFFFFFFFFFFF));
      l2 = norm_sq();
    end
    d = (l2 != 0) ? l2 : 64'd1;
    v = (64'd1 << (2 * F + 1)) / d;
    w = att_w; x = att_x; y = att_y; z = att_z;
    x2 = fprod(x, x); y2 = fprod(y, y); z2 = fprod(z, z);
    xy = fprod(x, y); wz = fprod(w, z); xz = fprod(x, z);
    wy = fprod(w, y); yz = fprod(y, z); wx = fprod(w, x);
    o.m00 = diag_entry(v, y2 + z2);
    o.m01 = off_entry(v, xy + wz);
    o.m02 = off_entry(v, xz - wy);
    o.m10 = off_entry(v, xy - wz);
    o.m11 = diag_entry(v, z2 + x2);
    o.m12 = off_entry(v, yz + wx);
    o.m20 = off_entry(v, xz + wy);
    o.m21 = off_entry(v, yz - wx);
    o.m22 = diag_entry(v, x2 + y2);
    o.renormalized = ren;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %t", field, got, want, $realtime);
    err_count++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // Typed expectations for directed rows that can be read at a glance
  logic known_pending = 1'b0;
  qitm_pkg::out_t known_result;

  // Predict on every accepted transaction, compare every delivered one
  always @(posedge clk) begin
    qitm_pkg::out_t want;
    if (rst) begin
      att_w = 32'sd1 <<< F;
      att_x = '0; att_y = '0; att_z = '0;
      step_reg = '0;
    end else begin
      if (cfg_valid && cfg_ready) step_reg = cfg_data;
      if (in_valid && in_ready) begin
        want = integrate_attitude(in_data);
        matrix_q.push_back(known_pending ? known_result : want);
      end
      if (out_valid && out_ready) begin
        if (matrix_q.size() == 0) begin
          $display("unexpected result transaction at %t", $realtime);
          err_count++;
        end else begin
          want = matrix_q.pop_front();
          check_field("m00", out_data.m00, want.m00);
          check_field("m01", out_data.m01, want.m01);
          check_field("m02", out_data.m02, want.m02);
          check_field("m10", out_data.m10, want.m10);
          check_field("m11", out_data.m11, want.m11);
          check_field("m12", out_data.m12, want.m12);
          check_field("m20", out_data.m20, want.m20);
          check_field("m21", out_data.m21, want.m21);
          check_field("m22", out_data.m22, want.m22);
          check_field("renormalized", 32'(out_data.renormalized), 32'(want.renormalized));
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here
  int recv_stall_pct = 0;
  int recv_hold = 0;
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_ready = 1'b0;
      recv_hold--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  int send_idle_pct = 0;

  task automatic send_rates(qitm_pkg::in_t r);
    @(negedge clk);
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  // Drain all results, then let the core settle before a register write
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (matrix_q.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_step(logic [23:0] s);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data = s;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_rate();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: return $signed(32'($urandom_range(8 << 20))) - (32'sd4 <<< 20);
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(7))
      0: return STEP_MAX;
      1: return '0;
      2: return 24'($urandom());
      default: return 24'($urandom_range(40000));
    endcase
  endfunction

  typedef struct {
    logic [23:0] step;
    qitm_pkg::in_t rates;
    bit known;
  } stim_row_t;

  localparam logic signed [31:0] RMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] RMIN = 32'sh80000000;
  localparam logic signed [31:0] R1 = 32'sd1 <<< 20;

  stim_row_t stim_rows[] = '{
    // zero step keeps identity whatever the rates
    '{24'd0, '{RMAX, RMAX, RMAX}, 1'b1},
    '{24'd0, '{RMIN, RMIN, RMIN}, 1'b1},
    '{24'd0, '{32'sd0, 32'sd0, 32'sd0}, 1'b1},
    '{24'd0, '{RMAX, RMIN, 32'sd1}, 1'b1},
    // gentle steps stay inside the tolerance band
    '{24'd16777, '{R1, 32'sd0, 32'sd0}, 1'b0},
    '{24'd16777, '{32'sd0, -R1, 32'sd0}, 1'b0},
    '{24'd16777, '{32'sd0, 32'sd0, R1}, 1'b0},
    '{24'd16777, '{-32'sd1, 32'sd1, -32'sd1}, 1'b0},
    '{24'd1, '{RMAX, RMAX, RMAX}, 1'b0},
    '{24'd1, '{RMIN, RMIN, RMIN}, 1'b0},
    // large steps push the norm out of band and saturate the state
    '{24'd1677722, '{R1, R1, -R1}, 1'b0},
    '{24'd1677722, '{4 * R1, -2 * R1, R1}, 1'b0},
    '{STEP_MAX, '{RMAX, 32'sd0, 32'sd0}, 1'b0},
    '{STEP_MAX, '{32'sd0, RMIN, 32'sd0}, 1'b0},
    '{STEP_MAX, '{32'sd0, 32'sd0, RMAX}, 1'b0},
    '{STEP_MAX, '{RMIN, RMIN, RMIN}, 1'b0},
    '{STEP_MAX, '{RMAX, RMAX, RMAX}, 1'b0},
    '{STEP_MAX, '{R1, -R1, R1}, 1'b0},
    '{24'd0, '{RMAX, RMIN, RMAX}, 1'b0}
  };

  initial begin
    logic [23:0] cur_step;
    qitm_pkg::in_t r;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_data = '0;
    in_valid = 1'b0; in_data = '0;
    known_result = '0;
    known_result.m00 = 32'sd1 <<< F;
    known_result.m11 = 32'sd1 <<< F;
    known_result.m22 = 32'sd1 <<< F;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    cur_step = '0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].step != cur_step || i == 0) begin
        write_step(stim_rows[i].step);
        cur_step = stim_rows[i].step;
      end
      known_pending = stim_rows[i].known;
      send_rates(stim_rows[i].rates);
      @(negedge clk);
      in_valid = 1'b0;
      known_pending = 1'b0;
    end

    // Random phases: mostly receiver stalls, then mostly sender idles, then neither
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 56 : 0;
      recv_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 18 : 0;
      for (int k = 0; k < 410; k++) begin
        if (k % 60 == 0) write_step(pick_step());
        // hold off the receiver while the sender keeps offering
        if (ph == 2 && k == 30) recv_hold = 3000;
        if (ph == 1 && k == 200) wait_drained();
        r.rate_x = pick_rate();
        r.rate_y = pick_rate();
        r.rate_z = pick_rate();
        send_rates(r);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (matrix_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
